// ===== src/afis_pkg.sv =====
// Shared widths, codes and types for the amide field-induced shift block.
`default_nettype none
package afis_pkg;
    localparam int unsigned CRD_W = 24;           // input coordinate width
    localparam int unsigned VEC_W = CRD_W + 1;    // coordinate difference width
    localparam int unsigned PRD_W = 2 * VEC_W;    // product of two differences
    localparam int unsigned SUM_W = PRD_W + 2;    // sum of three products
    localparam int unsigned SQ_W  = PRD_W;        // squared length width
    localparam int unsigned RT_W  = SQ_W / 2;     // square root width
    localparam int unsigned REM_W = RT_W + 2;     // square root remainder width
    localparam int unsigned SCL_W = 24;           // scale register width
    localparam int unsigned HLF_W = PRD_W / 2;    // multiplier split width
    localparam int unsigned NPP_W = SCL_W + HLF_W;  // scale times half magnitude
    localparam int unsigned NSUM_W = NPP_W + HLF_W; // scale times magnitude
    localparam int unsigned NUM_SH = 20;
    localparam int unsigned NUM_W = NSUM_W + NUM_SH;
    localparam int unsigned PP_W  = 2 * HLF_W;
    localparam int unsigned DEN_W = SQ_W + 2 * RT_W;
    localparam int unsigned Q_W   = 34;           // top bit flags overflow
    localparam int unsigned OUT_W = 32;
    localparam int unsigned NSQ   = RT_W;         // square root cells
    localparam int unsigned NDIV  = Q_W;          // divider cells

    localparam logic [SCL_W-1:0] SCALE_RST = 24'd2241200;
    localparam logic [1:0] SGN_POS = 2'b01;
    localparam logic [1:0] SGN_NEG = 2'b11;
    localparam logic [OUT_W-1:0] POS_MAX = 32'h7FFF_FFFF;
    localparam logic [OUT_W-1:0] NEG_MAX = 32'h8000_0000;

    typedef struct packed {
        logic       same;
        logic [1:0] sgn;
        logic       zero;
        logic       neg;
    } t_flg;
endpackage
`default_nettype wire

// ===== src/afis_sqrt_cell.sv =====
// One digit step of the square root chain: two input bits in, one root bit out.
`default_nettype none
module afis_sqrt_cell
    import afis_pkg::*;
(
    input  wire logic            i_clk,
    input  wire logic            i_en,
    input  wire logic [SQ_W-1:0]  i_x,
    input  wire logic [REM_W-1:0] i_rem,
    input  wire logic [RT_W-1:0]  i_root,
    output logic      [SQ_W-1:0]  o_x,
    output logic      [REM_W-1:0] o_rem,
    output logic      [RT_W-1:0]  o_root
);
    logic [REM_W+1:0] w_rem2;
    logic [REM_W+1:0] w_trial;
    logic [REM_W+1:0] w_diff;
    logic             w_ge;
    logic [SQ_W-1:0]  r_x;
    logic [REM_W-1:0] r_rem;
    logic [RT_W-1:0]  r_root;

    always_comb begin
        w_rem2  = {i_rem, i_x[SQ_W-1:SQ_W-2]};
        w_trial = {2'b00, i_root, 2'b01};
        w_ge    = (w_rem2 >= w_trial);
        w_diff  = w_rem2 - w_trial;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x    <= {i_x[SQ_W-3:0], 2'b00};
            r_rem  <= w_ge ? w_diff[REM_W-1:0] : w_rem2[REM_W-1:0];
            r_root <= {i_root[RT_W-2:0], w_ge};
        end
    end

    assign o_x    = r_x;
    assign o_rem  = r_rem;
    assign o_root = r_root;
endmodule
`default_nettype wire

// ===== src/afis_div_cell.sv =====
// One quotient bit of the restoring divider chain, at a fixed bit weight.
`default_nettype none
module afis_div_cell
    import afis_pkg::*;
#(
    parameter int unsigned SH = 0
)
(
    input  wire logic             i_clk,
    input  wire logic             i_en,
    input  wire logic [NUM_W-1:0] i_rem,
    input  wire logic [DEN_W-1:0] i_den,
    input  wire logic [Q_W-1:0]   i_q,
    output logic      [NUM_W-1:0] o_rem,
    output logic      [DEN_W-1:0] o_den,
    output logic      [Q_W-1:0]   o_q
);
    localparam int unsigned CW = DEN_W + Q_W;

    logic [CW-1:0]    w_dsh;
    logic [CW-1:0]    w_rx;
    logic [CW-1:0]    w_diff;
    logic             w_ge;
    logic [NUM_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [Q_W-1:0]   r_q;

    always_comb begin
        w_dsh  = CW'(i_den) << SH;
        w_rx   = CW'(i_rem);
        w_ge   = (w_rx >= w_dsh);
        w_diff = w_rx - w_dsh;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem <= w_ge ? w_diff[NUM_W-1:0] : i_rem;
            r_den <= i_den;
            r_q   <= {i_q[Q_W-2:0], w_ge};
        end
    end

    assign o_rem = r_rem;
    assign o_den = r_den;
    assign o_q   = r_q;
endmodule
`default_nettype wire

// ===== src/amide_field_induced_shift_core.sv =====
// Top level: pipelined amide field-induced chemical shift datapath.
//
// Input channel i_in_valid / o_in_ready carries one atom triple per transaction:
// charged atom, amide nitrogen and carbonyl carbon coordinates, the charge sign
// and the same-atom flag. Output channel o_out_valid / i_out_ready returns one
// transaction per input: the shift in 1/65536 ppm and the degenerate flag.
// i_cfg_we writes i_cfg_data into the scale register; write it only while idle.
//
// From acceptance to o_out_valid a transaction passes registered differences,
// products and sums, a 25-cell square root chain, a rounding register, the
// product, partial product and denominator registers, a 34-cell restoring
// divider chain and the output register. Throughput is one transaction per
// cycle unless the output stalls, set by the cell chains (one digit per stage).
//
// Reset clears every valid bit and loads the scale register with its default.
// When the output register holds a transaction that the receiver does not
// take, the whole pipeline holds and o_in_ready drops in the same cycle.
`default_nettype none
module amide_field_induced_shift_core
    import afis_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_cfg_we,
    input  wire logic [SCL_W-1:0]        i_cfg_data,
    input  wire logic                    i_in_valid,
    output logic                         o_in_ready,
    input  wire logic signed [CRD_W-1:0] i_charge_x,
    input  wire logic signed [CRD_W-1:0] i_charge_y,
    input  wire logic signed [CRD_W-1:0] i_charge_z,
    input  wire logic signed [CRD_W-1:0] i_nitrogen_x,
    input  wire logic signed [CRD_W-1:0] i_nitrogen_y,
    input  wire logic signed [CRD_W-1:0] i_nitrogen_z,
    input  wire logic signed [CRD_W-1:0] i_carbon_x,
    input  wire logic signed [CRD_W-1:0] i_carbon_y,
    input  wire logic signed [CRD_W-1:0] i_carbon_z,
    input  wire logic signed [1:0]       i_charge_sign,
    input  wire logic                    i_same_atom,
    output logic                         o_out_valid,
    input  wire logic                    i_out_ready,
    output logic signed [OUT_W-1:0]      o_shift_ppm,
    output logic                         o_degenerate
);
    localparam int unsigned PIPE_LEN = 3 + NSQ + 4 + NDIV + 1;

    logic                w_en;
    logic [PIPE_LEN-1:0] r_vld;
    logic [SCL_W-1:0]    r_scale;

    // differences
    logic signed [VEC_W-1:0] r_s1_ax, r_s1_ay, r_s1_az, r_s1_bx, r_s1_by, r_s1_bz;
    t_flg                    r_s1_flg;
    // products
    logic signed [PRD_W-1:0] r_s2_aa_x, r_s2_aa_y, r_s2_aa_z;
    logic signed [PRD_W-1:0] r_s2_bb_x, r_s2_bb_y, r_s2_bb_z;
    logic signed [PRD_W-1:0] r_s2_ab_x, r_s2_ab_y, r_s2_ab_z;
    t_flg                    r_s2_flg;
    // sums
    logic signed [SUM_W-1:0] w_dot, w_la2, w_lb2;
    logic [SUM_W-1:0]        w_dabs;
    logic [SQ_W-1:0]         r_s3_la2, r_s3_lb2, r_s3_dmag;
    t_flg                    r_s3_flg;

    // square root chain
    logic [SQ_W-1:0]  w_sqa_x    [0:NSQ];
    logic [REM_W-1:0] w_sqa_rem  [0:NSQ];
    logic [RT_W-1:0]  w_sqa_root [0:NSQ];
    logic [SQ_W-1:0]  w_sqb_x    [0:NSQ];
    logic [REM_W-1:0] w_sqb_rem  [0:NSQ];
    logic [RT_W-1:0]  w_sqb_root [0:NSQ];
    logic [SQ_W-1:0]  r_sq_la2   [0:NSQ-1];
    logic [SQ_W-1:0]  r_sq_dmag  [0:NSQ-1];
    t_flg             r_sq_flg   [0:NSQ-1];

    // rounding and multiplies
    logic             w_rnd_a, w_rnd_b;
    logic [RT_W-1:0]  r_rnd_la, r_rnd_lb;
    logic [SQ_W-1:0]  r_rnd_la2, r_rnd_dmag;
    t_flg             r_rnd_flg;
    logic [PP_W-1:0]  r_mul_p;
    logic [NPP_W-1:0] r_mul_nlo, r_mul_nhi;
    logic [SQ_W-1:0]  r_mul_la2;
    t_flg             r_mul_flg;
    logic [NSUM_W-1:0] w_nsum;
    logic [PP_W-1:0]  r_pp_00, r_pp_01, r_pp_10, r_pp_11;
    logic [NUM_W-1:0] r_pp_num;
    t_flg             r_pp_flg;
    logic [DEN_W-1:0] r_den;
    logic [NUM_W-1:0] r_den_num;
    t_flg             r_den_flg;

    // divider chain
    logic [NUM_W-1:0] w_dv_rem [0:NDIV];
    logic [DEN_W-1:0] w_dv_den [0:NDIV];
    logic [Q_W-1:0]   w_dv_q   [0:NDIV];
    t_flg             r_dv_flg [0:NDIV-1];

    // output
    t_flg             w_fin_flg;
    logic [Q_W-1:0]   w_fin_q;
    logic             w_sat;
    logic [OUT_W-1:0] w_shift;
    logic             w_deg;
    logic [OUT_W-1:0] r_out_shift;
    logic             r_out_deg;

    assign w_en       = !r_vld[PIPE_LEN-1] || i_out_ready;
    assign o_in_ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            r_scale <= SCALE_RST;
        end else begin
            if (w_en) begin
                r_vld <= {r_vld[PIPE_LEN-2:0], i_in_valid};
            end
            if (i_cfg_we) begin
                r_scale <= i_cfg_data;
            end
        end
    end

    // differences, products, sums
    always_comb begin
        w_dot  = SUM_W'(r_s2_ab_x) + SUM_W'(r_s2_ab_y) + SUM_W'(r_s2_ab_z);
        w_la2  = SUM_W'(r_s2_aa_x) + SUM_W'(r_s2_aa_y) + SUM_W'(r_s2_aa_z);
        w_lb2  = SUM_W'(r_s2_bb_x) + SUM_W'(r_s2_bb_y) + SUM_W'(r_s2_bb_z);
        w_dabs = w_dot[SUM_W-1] ? -w_dot : w_dot;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_ax  <= VEC_W'(i_charge_x) - VEC_W'(i_nitrogen_x);
            r_s1_ay  <= VEC_W'(i_charge_y) - VEC_W'(i_nitrogen_y);
            r_s1_az  <= VEC_W'(i_charge_z) - VEC_W'(i_nitrogen_z);
            r_s1_bx  <= VEC_W'(i_carbon_x) - VEC_W'(i_nitrogen_x);
            r_s1_by  <= VEC_W'(i_carbon_y) - VEC_W'(i_nitrogen_y);
            r_s1_bz  <= VEC_W'(i_carbon_z) - VEC_W'(i_nitrogen_z);
            r_s1_flg <= '{same: i_same_atom, sgn: i_charge_sign, zero: 1'b0, neg: 1'b0};

            r_s2_aa_x <= PRD_W'(r_s1_ax) * PRD_W'(r_s1_ax);
            r_s2_aa_y <= PRD_W'(r_s1_ay) * PRD_W'(r_s1_ay);
            r_s2_aa_z <= PRD_W'(r_s1_az) * PRD_W'(r_s1_az);
            r_s2_bb_x <= PRD_W'(r_s1_bx) * PRD_W'(r_s1_bx);
            r_s2_bb_y <= PRD_W'(r_s1_by) * PRD_W'(r_s1_by);
            r_s2_bb_z <= PRD_W'(r_s1_bz) * PRD_W'(r_s1_bz);
            r_s2_ab_x <= PRD_W'(r_s1_ax) * PRD_W'(r_s1_bx);
            r_s2_ab_y <= PRD_W'(r_s1_ay) * PRD_W'(r_s1_by);
            r_s2_ab_z <= PRD_W'(r_s1_az) * PRD_W'(r_s1_bz);
            r_s2_flg  <= r_s1_flg;

            r_s3_la2  <= w_la2[SQ_W-1:0];
            r_s3_lb2  <= w_lb2[SQ_W-1:0];
            r_s3_dmag <= w_dabs[SQ_W-1:0];
            r_s3_flg  <= '{same: r_s2_flg.same, sgn: r_s2_flg.sgn,
                           zero: (w_la2 == '0) || (w_lb2 == '0),
                           neg:  w_dot[SUM_W-1] ^ (r_s2_flg.sgn == SGN_NEG)};
        end
    end

    // square root chains for both lengths
    assign w_sqa_x[0]    = r_s3_la2;
    assign w_sqa_rem[0]  = '0;
    assign w_sqa_root[0] = '0;
    assign w_sqb_x[0]    = r_s3_lb2;
    assign w_sqb_rem[0]  = '0;
    assign w_sqb_root[0] = '0;

    for (genvar g = 0; g < NSQ; g++) begin : g_sq
        afis_sqrt_cell u_sqa (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_x    (w_sqa_x[g]),
            .i_rem  (w_sqa_rem[g]),
            .i_root (w_sqa_root[g]),
            .o_x    (w_sqa_x[g+1]),
            .o_rem  (w_sqa_rem[g+1]),
            .o_root (w_sqa_root[g+1])
        );
        afis_sqrt_cell u_sqb (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_x    (w_sqb_x[g]),
            .i_rem  (w_sqb_rem[g]),
            .i_root (w_sqb_root[g]),
            .o_x    (w_sqb_x[g+1]),
            .o_rem  (w_sqb_rem[g+1]),
            .o_root (w_sqb_root[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sq_la2[0]  <= r_s3_la2;
            r_sq_dmag[0] <= r_s3_dmag;
            r_sq_flg[0]  <= r_s3_flg;
            for (int k = 1; k < NSQ; k++) begin
                r_sq_la2[k]  <= r_sq_la2[k-1];
                r_sq_dmag[k] <= r_sq_dmag[k-1];
                r_sq_flg[k]  <= r_sq_flg[k-1];
            end
        end
    end

    // round to nearest, then form numerator and denominator
    always_comb begin
        w_rnd_a = w_sqa_rem[NSQ] > REM_W'(w_sqa_root[NSQ]);
        w_rnd_b = w_sqb_rem[NSQ] > REM_W'(w_sqb_root[NSQ]);
        w_nsum  = {r_mul_nhi, {HLF_W{1'b0}}} + NSUM_W'(r_mul_nlo);
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_rnd_la   <= w_sqa_root[NSQ] + {{(RT_W-1){1'b0}}, w_rnd_a};
            r_rnd_lb   <= w_sqb_root[NSQ] + {{(RT_W-1){1'b0}}, w_rnd_b};
            r_rnd_la2  <= r_sq_la2[NSQ-1];
            r_rnd_dmag <= r_sq_dmag[NSQ-1];
            r_rnd_flg  <= r_sq_flg[NSQ-1];

            r_mul_p   <= PP_W'(r_rnd_la) * PP_W'(r_rnd_lb);
            r_mul_nlo <= NPP_W'(r_scale) * NPP_W'(r_rnd_dmag[HLF_W-1:0]);
            r_mul_nhi <= NPP_W'(r_scale) * NPP_W'(r_rnd_dmag[SQ_W-1:HLF_W]);
            r_mul_la2 <= r_rnd_la2;
            r_mul_flg <= r_rnd_flg;

            r_pp_00  <= PP_W'(r_mul_la2[HLF_W-1:0]) * PP_W'(r_mul_p[HLF_W-1:0]);
            r_pp_01  <= PP_W'(r_mul_la2[HLF_W-1:0]) * PP_W'(r_mul_p[PP_W-1:HLF_W]);
            r_pp_10  <= PP_W'(r_mul_la2[SQ_W-1:HLF_W]) * PP_W'(r_mul_p[HLF_W-1:0]);
            r_pp_11  <= PP_W'(r_mul_la2[SQ_W-1:HLF_W]) * PP_W'(r_mul_p[PP_W-1:HLF_W]);
            r_pp_num <= {w_nsum, {NUM_SH{1'b0}}};
            r_pp_flg <= r_mul_flg;

            r_den     <= (DEN_W'(r_pp_11) << (2 * HLF_W))
                       + ((DEN_W'(r_pp_01) + DEN_W'(r_pp_10)) << HLF_W)
                       + DEN_W'(r_pp_00);
            r_den_num <= r_pp_num;
            r_den_flg <= r_pp_flg;
        end
    end

    // divider chain, most significant quotient bit first
    assign w_dv_rem[0] = r_den_num;
    assign w_dv_den[0] = r_den;
    assign w_dv_q[0]   = '0;

    for (genvar g = 0; g < NDIV; g++) begin : g_dv
        afis_div_cell #(
            .SH (NDIV - 1 - g)
        ) u_dv (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_rem (w_dv_rem[g]),
            .i_den (w_dv_den[g]),
            .i_q   (w_dv_q[g]),
            .o_rem (w_dv_rem[g+1]),
            .o_den (w_dv_den[g+1]),
            .o_q   (w_dv_q[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dv_flg[0] <= r_den_flg;
            for (int k = 1; k < NDIV; k++) begin
                r_dv_flg[k] <= r_dv_flg[k-1];
            end
        end
    end

    // special cases, sign and saturation
    always_comb begin
        w_fin_flg = r_dv_flg[NDIV-1];
        w_fin_q   = w_dv_q[NDIV];
        w_sat     = 1'b0;
        w_shift   = '0;
        w_deg     = 1'b0;
        if (w_fin_flg.same) begin
            w_deg = 1'b0;
        end else if (w_fin_flg.zero) begin
            w_deg = 1'b1;
        end else if (w_fin_flg.sgn == SGN_POS || w_fin_flg.sgn == SGN_NEG) begin
            if (w_fin_flg.neg) begin
                w_sat   = w_fin_q[Q_W-1] || w_fin_q[Q_W-2]
                       || (w_fin_q[OUT_W-1] && (w_fin_q[OUT_W-2:0] != '0));
                w_shift = w_sat ? NEG_MAX : (OUT_W'(0) - w_fin_q[OUT_W-1:0]);
            end else begin
                w_sat   = (w_fin_q[Q_W-1:OUT_W-1] != '0);
                w_shift = w_sat ? POS_MAX : w_fin_q[OUT_W-1:0];
            end
            w_deg = w_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_shift <= w_shift;
            r_out_deg   <= w_deg;
        end
    end

    assign o_out_valid  = r_vld[PIPE_LEN-1];
    assign o_shift_ppm  = r_out_shift;
    assign o_degenerate = r_out_deg;

`ifndef SYNTHESIS
    a_deg_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_degenerate) |->
            (o_shift_ppm == 0 || r_out_shift == POS_MAX || r_out_shift == NEG_MAX))
        else $error("degenerate result with a value that is neither zero nor a limit");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(r_vld))
        else $error("pipeline moved while the output was stalled");

    a_scale_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> (r_scale == SCALE_RST))
        else $error("scale register not at default after reset");
`endif
endmodule
`default_nettype wire
